>>> hdl/bmfq_pkg.sv
// ----------------------------------------------------------------------------
// bmfq_pkg
// Widths and codes shared by the bounded min-id frame queue.
// ----------------------------------------------------------------------------
package bmfq_pkg;

  localparam int NUM_W    = 31;
  localparam int HDL_W    = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_TAKE  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 3'd0,
    ST_EVICTED = 3'd1,
    ST_TAKEN   = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_WRITE,
    S_SWEEP,
    S_SWEEP_LAST
  } state_e;

endpackage

>>> hdl/bounded_min_id_frame_queue.sv
// ----------------------------------------------------------------------------
// bounded_min_id_frame_queue
// Fixed-capacity priority queue of frame tags keyed by frame number.
// ----------------------------------------------------------------------------
// Usage: an operation (func_i, frame_number_i, frame_handle_i) transfers in at
// a rising edge with start_i high and busy_o low. Push stores a tag (evicting
// the smallest, oldest first among equal keys, when full), take removes and
// returns the smallest, clear empties the queue; an unused func code is
// dropped without a result. Each operation gives one result on status_o,
// out_number_o, out_handle_o and occupancy_o, valid for the single cycle in
// which done_o is high; the receiver takes it in that cycle and cannot stall.
// Push into a non-full queue, take from an empty one and clear give done_o
// in the cycle after the transfer. A take or a push into a full queue
// runs a scan over the n held entries and then an age-rank fix-up sweep over
// the entries left, both through the one read port of the entry memory, one
// entry per cycle; a take of the only entry skips the sweep. busy_o stays
// high meanwhile; the next operation can transfer in the cycle that its
// result is out. Reset empties the queue at once; the entry memory itself
// is not cleared.
// ----------------------------------------------------------------------------
module bounded_min_id_frame_queue #(
  parameter int CAPACITY = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bmfq_pkg::FUNC_W-1:0]    func_i,
  input  logic [bmfq_pkg::NUM_W-1:0]     frame_number_i,
  input  logic [bmfq_pkg::HDL_W-1:0]     frame_handle_i,
  output logic                           done_o,
  output logic [bmfq_pkg::STATUS_W-1:0]  status_o,
  output logic [bmfq_pkg::NUM_W-1:0]     out_number_o,
  output logic [bmfq_pkg::HDL_W-1:0]     out_handle_o,
  output logic [bmfq_pkg::OCC_W-1:0]     occupancy_o
);

  import bmfq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = NUM_W + HDL_W + IW;

  // entry memory: {number, handle, age rank}
  logic [WW-1:0] mem_q [CAPACITY];
  logic [WW-1:0] rd_data_q;

  logic          we;
  logic [IW-1:0] wa;
  logic [WW-1:0] wd;

  state_e        state_q, state_d;
  func_e         func_q, func_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [HDL_W-1:0] hdl_q, hdl_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] pi_q, pi_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [NUM_W-1:0] best_num_q, best_num_d;
  logic [HDL_W-1:0] best_hdl_q, best_hdl_d;
  logic [IW-1:0] best_ord_q, best_ord_d;
  logic [WW-1:0] last_word_q, last_word_d;
  logic          done_q, done_d;
  status_e       status_q, status_d;
  logic [NUM_W-1:0] onum_q, onum_d;
  logic [HDL_W-1:0] ohdl_q, ohdl_d;
  logic [OCC_W-1:0] occ_q, occ_d;

  logic [NUM_W-1:0] r_num;
  logic [HDL_W-1:0] r_hdl;
  logic [IW-1:0]    r_ord;
  logic [IW-1:0]    last_idx;
  logic [CW-1:0]    fill_dec;

  assign r_num    = rd_data_q[WW-1 -: NUM_W];
  assign r_hdl    = rd_data_q[IW +: HDL_W];
  assign r_ord    = rd_data_q[IW-1:0];
  assign fill_dec = fill_q - CW'(1);
  assign last_idx = IW'(fill_dec);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_data_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    num_q       <= num_d;
    hdl_q       <= hdl_d;
    pi_q        <= pi_d;
    best_idx_q  <= best_idx_d;
    best_num_q  <= best_num_d;
    best_hdl_q  <= best_hdl_d;
    best_ord_q  <= best_ord_d;
    last_word_q <= last_word_d;
    status_q    <= status_d;
    onum_q      <= onum_d;
    ohdl_q      <= ohdl_d;
    occ_q       <= occ_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    num_d       = num_q;
    hdl_d       = hdl_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    pi_d        = idx_q;
    best_idx_d  = best_idx_q;
    best_num_d  = best_num_q;
    best_hdl_d  = best_hdl_q;
    best_ord_d  = best_ord_q;
    last_word_d = last_word_q;
    done_d      = 1'b0;
    status_d    = status_q;
    onum_d      = onum_q;
    ohdl_d      = ohdl_q;
    occ_d       = occ_q;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;

    // min search over entries read back from memory
    if (pv_q && (state_q == S_SCAN || state_q == S_SCAN_LAST)) begin
      if (pi_q == '0 || r_num < best_num_q ||
          (r_num == best_num_q && r_ord < best_ord_q)) begin
        best_idx_d = pi_q;
        best_num_d = r_num;
        best_hdl_d = r_hdl;
        best_ord_d = r_ord;
      end
      if (pi_q == last_idx) begin
        last_word_d = rd_data_q;
      end
    end

    // age rank fix-up
    if (pv_q && (state_q == S_SWEEP || state_q == S_SWEEP_LAST)) begin
      if (r_ord > best_ord_q && !(func_q == FUNC_PUSH && pi_q == best_idx_q)) begin
        we = 1'b1;
        wa = pi_q;
        wd = {r_num, r_hdl, r_ord - IW'(1)};
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = func_e'(func_i);
          num_d  = frame_number_i;
          hdl_d  = frame_handle_i;
          idx_d  = '0;
          case (func_e'(func_i))
            FUNC_PUSH: begin
              if (fill_q < CW'(CAPACITY)) begin
                we       = 1'b1;
                wa       = IW'(fill_q);
                wd       = {frame_number_i, frame_handle_i, IW'(fill_q)};
                fill_d   = fill_q + CW'(1);
                done_d   = 1'b1;
                status_d = ST_PUSHED;
                onum_d   = '0;
                ohdl_d   = '0;
                occ_d    = OCC_W'(fill_d);
              end else begin
                state_d = S_SCAN;
              end
            end
            FUNC_TAKE: begin
              if (fill_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
                onum_d   = '0;
                ohdl_d   = '0;
                occ_d    = '0;
              end else begin
                state_d = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              fill_d   = '0;
              done_d   = 1'b1;
              status_d = ST_CLEARED;
              onum_d   = '0;
              ohdl_d   = '0;
              occ_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        pv_d = 1'b1;
        if (idx_q == last_idx) begin
          state_d = S_SCAN_LAST;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_SCAN_LAST: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we     = 1'b1;
        wa     = best_idx_q;
        onum_d = best_num_q;
        ohdl_d = best_hdl_q;
        idx_d  = '0;
        if (func_q == FUNC_TAKE) begin
          wd       = last_word_q;
          fill_d   = fill_dec;
          status_d = ST_TAKEN;
        end else begin
          wd       = {num_q, hdl_q, IW'(CAPACITY - 1)};
          status_d = ST_EVICTED;
        end
        occ_d = OCC_W'(fill_d);
        if (fill_d == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        pv_d = 1'b1;
        if (idx_q == last_idx) begin
          state_d = S_SWEEP_LAST;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_SWEEP_LAST: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_number_o = onum_q;
  assign out_handle_o = ohdl_q;
  assign occupancy_o  = occ_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_CLEAR) |=>
      (done_o && status_o == ST_CLEARED && fill_q == '0))
    else $error("clear did not empty the queue");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (CW'(pi_q) < fill_q))
    else $error("entry access beyond held entries");

endmodule
